### rtl/core/postfix_stack_evaluator_macros.svh
// Assertion macros used by the checker file.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, off during reset.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Check what reset leaves behind.
`define PSE_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pse_pkg.sv
`default_nettype none
package pse_pkg;

    localparam int VAL_W     = 40;
    localparam int LIT_W     = 16;
    localparam int CMD_W     = 3;
    localparam int ST_W      = 2;
    localparam int FRAC_W    = 16;
    localparam int HALF_W    = VAL_W / 2;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int MAG_W     = PROD_W - FRAC_W;
    localparam int DVD_W     = VAL_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 4;
    localparam int M_TDATA_W = ((VAL_W + ST_W + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - VAL_W - ST_W;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic        [VAL_W-1:0] mag_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_END  = 3'd5
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef struct packed {
        logic start;
        cmd_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic divz;
    } alu_rsp_t;

endpackage
`default_nettype wire

### rtl/core/pse_stack_mem.sv
`default_nettype none
module pse_stack_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic           aclk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire pse_pkg::val_t  wr_data,
    input  wire logic [AW-1:0]  rd_addr_a,
    input  wire logic [AW-1:0]  rd_addr_b,
    output pse_pkg::val_t       rd_data_a,
    output pse_pkg::val_t       rd_data_b
);

    pse_pkg::val_t stack_mem [DEPTH];
    pse_pkg::val_t rd_a_reg;
    pse_pkg::val_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= stack_mem[rd_addr_a];
        rd_b_reg <= stack_mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
`default_nettype wire

### rtl/core/pse_alu.sv
`default_nettype none
module pse_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pse_pkg::alu_req_t req,
    input  wire pse_pkg::val_t     left,
    input  wire pse_pkg::val_t     right,
    output pse_pkg::alu_rsp_t      rsp,
    output pse_pkg::val_t          result
);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_state_t;

    alu_state_t                            state_reg;
    pse_pkg::cmd_t                         op_reg;
    logic                                  neg_reg;
    pse_pkg::mag_t                         a_reg;
    pse_pkg::mag_t                         b_reg;
    logic [pse_pkg::PROD_W-1:0]            acc_reg;
    logic [pse_pkg::DVD_W-1:0]             dvd_reg;
    logic [pse_pkg::VAL_W-1:0]             rem_reg;
    logic [pse_pkg::STEP_W-1:0]            step_reg;
    logic                                  done_reg;
    logic                                  divz_reg;
    pse_pkg::val_t                         result_reg;

    logic                                  done_next;
    logic                                  divz_next;
    logic [pse_pkg::HALF_W-1:0]            a_half;
    logic [pse_pkg::HALF_W-1:0]            b_half;
    logic [pse_pkg::VAL_W-1:0]             pp;
    logic [pse_pkg::PROD_W-1:0]            pp_sh;
    logic signed [pse_pkg::VAL_W:0]        sum_w;
    pse_pkg::val_t                         sum_sat;
    logic [pse_pkg::VAL_W:0]               trial;
    logic [pse_pkg::VAL_W+1:0]             diff;
    logic                                  ge;
    logic [pse_pkg::MAG_W-1:0]             fin_mag;

    function automatic pse_pkg::mag_t magnitude(pse_pkg::val_t v);
        pse_pkg::val_t n;
        n = -v;
        return v[pse_pkg::VAL_W-1] ? pse_pkg::mag_t'(n) : pse_pkg::mag_t'(v);
    endfunction

    function automatic pse_pkg::val_t sat_mag(logic [pse_pkg::MAG_W-1:0] mag, logic neg);
        logic          big;
        pse_pkg::val_t low;
        big = |mag[pse_pkg::MAG_W-1:pse_pkg::VAL_W-1];
        low = pse_pkg::val_t'(mag[pse_pkg::VAL_W-1:0]);
        if (neg) begin
            return big ? pse_pkg::VAL_MIN : -low;
        end
        return big ? pse_pkg::VAL_MAX : low;
    endfunction

    assign a_half = step_reg[1] ? a_reg[pse_pkg::VAL_W-1:pse_pkg::HALF_W]
                                : a_reg[pse_pkg::HALF_W-1:0];
    assign b_half = step_reg[0] ? b_reg[pse_pkg::VAL_W-1:pse_pkg::HALF_W]
                                : b_reg[pse_pkg::HALF_W-1:0];
    assign pp = a_half * b_half;

    always_comb begin
        unique case (step_reg[1:0])
            2'b00:        pp_sh = pse_pkg::PROD_W'(pp);
            2'b01, 2'b10: pp_sh = pse_pkg::PROD_W'(pp) << pse_pkg::HALF_W;
            default:      pp_sh = pse_pkg::PROD_W'(pp) << (2 * pse_pkg::HALF_W);
        endcase
    end

    assign sum_w = (req.op == pse_pkg::CMD_ADD)
                 ? {left[pse_pkg::VAL_W-1], left} + {right[pse_pkg::VAL_W-1], right}
                 : {left[pse_pkg::VAL_W-1], left} - {right[pse_pkg::VAL_W-1], right};

    always_comb begin
        if (sum_w[pse_pkg::VAL_W] != sum_w[pse_pkg::VAL_W-1]) begin
            sum_sat = sum_w[pse_pkg::VAL_W] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
        end else begin
            sum_sat = sum_w[pse_pkg::VAL_W-1:0];
        end
    end

    assign trial = {rem_reg, dvd_reg[pse_pkg::DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, b_reg};
    assign ge    = !diff[pse_pkg::VAL_W+1];

    assign fin_mag = (op_reg == pse_pkg::CMD_MUL)
                   ? acc_reg[pse_pkg::PROD_W-1:pse_pkg::FRAC_W]
                   : pse_pkg::MAG_W'(dvd_reg);

    assign divz_next = (state_reg == A_IDLE) && req.start
                     && (req.op == pse_pkg::CMD_DIV) && (right == '0);
    assign done_next = (state_reg == A_FIN)
                     || ((state_reg == A_IDLE) && req.start && (req.op != pse_pkg::CMD_MUL)
                         && ((req.op != pse_pkg::CMD_DIV) || (right == '0)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            divz_reg  <= 1'b0;
        end else begin
            done_reg <= done_next;
            divz_reg <= divz_next;
            unique case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        op_reg   <= req.op;
                        neg_reg  <= left[pse_pkg::VAL_W-1] ^ right[pse_pkg::VAL_W-1];
                        a_reg    <= magnitude(left);
                        b_reg    <= magnitude(right);
                        acc_reg  <= '0;
                        rem_reg  <= '0;
                        step_reg <= '0;
                        dvd_reg  <= {magnitude(left), {pse_pkg::FRAC_W{1'b0}}};
                        unique case (req.op)
                            pse_pkg::CMD_ADD, pse_pkg::CMD_SUB: begin
                                result_reg <= sum_sat;
                            end
                            pse_pkg::CMD_MUL: begin
                                state_reg <= A_MUL;
                            end
                            pse_pkg::CMD_DIV: begin
                                if (right == '0) begin
                                    result_reg <= '0;
                                end else begin
                                    state_reg <= A_DIV;
                                end
                            end
                            default: begin
                                result_reg <= left;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    acc_reg  <= acc_reg + pp_sh;
                    step_reg <= step_reg + pse_pkg::STEP_W'(1);
                    if (step_reg[1:0] == 2'(pse_pkg::MUL_STEPS - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_DIV: begin
                    rem_reg  <= ge ? diff[pse_pkg::VAL_W-1:0] : trial[pse_pkg::VAL_W-1:0];
                    dvd_reg  <= {dvd_reg[pse_pkg::DVD_W-2:0], ge};
                    step_reg <= step_reg + pse_pkg::STEP_W'(1);
                    if (step_reg == pse_pkg::STEP_W'(pse_pkg::DIV_STEPS - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    result_reg <= sat_mag(fin_mag, neg_reg);
                    state_reg  <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.divz = divz_reg;
    assign result   = result_reg;

endmodule
`default_nettype wire

### rtl/core/postfix_stack_evaluator.sv
// Postfix evaluator on a signed Q24.16 operand stack of STACK_DEPTH entries held in a
// synchronous RAM. Each input word carries a token kind in s_tuser and a 16-bit unsigned
// literal in s_tdata; push stores literal*2^16, add/subtract/multiply/divide pop right then
// left and push the saturated result, and end returns the top value (zero when empty) with
// a sticky status (ok, underflow, overflow, divide by zero) and clears the stack. Only end
// produces an output word: value in m_tdata[39:0], status in m_tdata[41:40]. One token is
// worked on at a time; multiply accumulates four 20x20 partial products one per cycle and
// divide uses a restoring divider producing one of 56 quotient bits per cycle. An end token
// waits until the output register is free; the output register lets the next token be
// taken while a result waits downstream.
`default_nettype none
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pse_pkg::LIT_W-1:0]       s_tdata,   // [15:0] literal
    input  wire logic [pse_pkg::CMD_W-1:0]       s_tuser,   // [2:0] cmd
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pse_pkg::M_TDATA_W-1:0]        m_tdata    // [39:0] value, [41:40] status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_OP, S_WAIT, S_END} state_t;

    state_t                         state_reg;
    pse_pkg::cmd_t                  cmd_reg;
    logic [CW-1:0]                  count_reg;
    pse_pkg::status_t               err_reg;
    logic                           m_tvalid_reg;
    logic [pse_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic                           s_accept;
    pse_pkg::cmd_t                  cmd_in;
    logic [CW-1:0]                  cnt_m1;
    logic [CW-1:0]                  cnt_m2;
    logic                           full;
    logic                           empty;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    pse_pkg::val_t                  wr_data;
    pse_pkg::val_t                  rd_a;
    pse_pkg::val_t                  rd_b;
    pse_pkg::alu_req_t              alu_req;
    pse_pkg::alu_rsp_t              alu_rsp;
    pse_pkg::val_t                  alu_result;
    pse_pkg::status_t               end_status;
    pse_pkg::val_t                  end_value;

    function automatic pse_pkg::status_t raise_err(pse_pkg::status_t cur,
                                                   pse_pkg::status_t code);
        return (cur == pse_pkg::ST_OK) ? code : cur;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cmd_in   = pse_pkg::cmd_t'(s_tuser);
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign empty    = (count_reg == '0);

    assign wr_en   = (s_accept && (cmd_in == pse_pkg::CMD_PUSH) && !full)
                   || ((state_reg == S_WAIT) && alu_rsp.done);
    assign wr_addr = (state_reg == S_WAIT) ? cnt_m2[AW-1:0] : count_reg[AW-1:0];
    assign wr_data = (state_reg == S_WAIT)
                   ? alu_result
                   : pse_pkg::val_t'({{(pse_pkg::VAL_W - pse_pkg::LIT_W - pse_pkg::FRAC_W){1'b0}},
                                      s_tdata, {pse_pkg::FRAC_W{1'b0}}});

    assign alu_req.start = (state_reg == S_OP);
    assign alu_req.op    = cmd_reg;

    assign end_status = empty ? raise_err(err_reg, pse_pkg::ST_UNDER) : err_reg;
    assign end_value  = empty ? '0 : rd_a;

    pse_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (cnt_m1[AW-1:0]),
        .rd_addr_b (cnt_m2[AW-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .left    (rd_b),
        .right   (rd_a),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            err_reg      <= pse_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_END)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        cmd_reg <= cmd_in;
                        unique case (cmd_in)
                            pse_pkg::CMD_PUSH: begin
                                if (full) begin
                                    err_reg <= raise_err(err_reg, pse_pkg::ST_OVER);
                                end else begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            pse_pkg::CMD_ADD, pse_pkg::CMD_SUB,
                            pse_pkg::CMD_MUL, pse_pkg::CMD_DIV: begin
                                if (count_reg < CW'(2)) begin
                                    err_reg <= raise_err(err_reg, pse_pkg::ST_UNDER);
                                end else begin
                                    state_reg <= S_OP;
                                end
                            end
                            pse_pkg::CMD_END: begin
                                state_reg <= S_END;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_OP: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        count_reg <= cnt_m1;
                        if (alu_rsp.divz) begin
                            err_reg <= raise_err(err_reg, pse_pkg::ST_DIVZ);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_END: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{pse_pkg::PAD_W{1'b0}}, end_status, end_value};
                        count_reg    <= '0;
                        err_reg      <= pse_pkg::ST_OK;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### rtl/core/pse_checker.sv
`default_nettype none
`include "postfix_stack_evaluator_macros.svh"
module pse_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [pse_pkg::LIT_W-1:0]       s_tdata,
    input wire logic [pse_pkg::CMD_W-1:0]       s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pse_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic end_accept;
    logic end_free;
    logic out_stall;
    logic pad_clear;

    assign end_accept = s_tvalid && s_tready && (s_tuser == pse_pkg::CMD_END);
    assign end_free   = end_accept && (!m_tvalid || m_tready);
    assign out_stall  = m_tvalid && !m_tready;
    assign pad_clear  = (m_tdata[pse_pkg::M_TDATA_W-1:pse_pkg::VAL_W+pse_pkg::ST_W] == '0);

    `PSE_ASSERT_RST(a_reset_idle, !m_tvalid && s_tready, "output or input side busy after reset")

    `PSE_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled word changed")

    `PSE_ASSERT_NXT(a_end_busy, end_accept, !s_tready, "input taken while end token pending")

    `PSE_ASSERT_NXT(a_end_emit, end_free, ##1 m_tvalid, "end token gave no output word")

    `PSE_ASSERT_IMP(a_pad_zero, m_tvalid, pad_clear, "output padding not zero")

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
